// ===== rtl/sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_defines.svh
// Assertion macros used by the priority queue checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq next-cycle check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;

    // Operation codes carried on s_tuser
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Contents of one queue slot
    typedef struct packed {
        logic                      valid;
        logic [VALUE_W-1:0]        value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                      enq;
        logic                      deq;
        logic [VALUE_W-1:0]        value;
        logic signed [PRIO_W-1:0]  prio;
    } cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: compares against the new priority and
// shifts toward the tail on insert or toward the head on removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  spq_pkg::cmd_t  cmd,
    input  spq_pkg::entry_t left_entry,  // neighbor toward the head
    input  logic           left_disp,   // neighbor gives way to the new word
    input  spq_pkg::entry_t right_entry, // neighbor toward the tail
    output spq_pkg::entry_t entry,
    output logic           disp
);
    import spq_pkg::*;

    logic                     valid_reg, valid_next;
    logic [VALUE_W-1:0]       value_reg, value_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;

    // Give way when empty or holding a priority not above the new one
    assign disp = !valid_reg || (prio_reg <= cmd.prio);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.enq && disp)
        begin
            valid_next = left_entry.valid;
            if (left_disp)
            begin
                value_next = left_entry.value;
                prio_next  = left_entry.prio;
            end
            else
            begin
                value_next = cmd.value;
                prio_next  = cmd.prio;
            end
        end
        else if (cmd.deq)
        begin
            valid_next = right_entry.valid;
            value_next = right_entry.value;
            prio_next  = right_entry.prio;
        end
    end

    // Hold occupancy under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold slot payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;
    assign entry.prio  = prio_reg;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held sorted in a row of cells, highest priority at
// the head; equal priorities leave newest first.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  s_*     | in  | item_value, item_priority      | kind (0 enq, 1 deq)
//  m_*     | out | out_value, out_priority        | status
//
//  Every cell compares and shifts in parallel at the accepting edge, which
//  also loads the result register; the result shows on m_* in the cycle
//  after.
//  A new word is taken while the output register is empty or being drained.
//  rst_n clears all occupancy bits and the output valid; slot payload is kept.
//  A stall on m_tready holds the result and blocks s_tready only while held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] out_value, [47:32] out_priority
    output logic [1:0]  m_tuser    // [1:0] status
);
    import spq_pkg::*;

    cmd_t   cmd;
    entry_t cells   [DEPTH];
    logic   disps   [DEPTH];
    logic   accept, full, empty;

    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic [VALUE_W-1:0]       out_value_reg, out_value_next;
    logic signed [PRIO_W-1:0] out_prio_reg, out_prio_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = cells[DEPTH-1].valid;
    assign empty    = !cells[0].valid;

    // Broadcast the operation to every cell
    assign cmd.enq   = accept && (s_tuser[0] == KIND_ENQ) && !full;
    assign cmd.deq   = accept && (s_tuser[0] == KIND_DEQ) && !empty;
    assign cmd.value = s_tdata[31:0];
    assign cmd.prio  = s_tdata[47:32];

    // Chain of slots, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_d;
        if (i == 0)
        begin : g_head
            assign left_e = '{valid: 1'b1, value: '0, prio: '0};
            assign left_d = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cells[i-1];
            assign left_d = disps[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = '{valid: 1'b0, value: '0, prio: '0};
        end
        else
        begin : g_inner
            assign right_e = cells[i+1];
        end
        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_disp   (left_d),
            .right_entry (right_e),
            .entry       (cells[i]),
            .disp        (disps[i])
        );
    end

    // Form the result word
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        out_prio_next  = out_prio_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            out_prio_next  = '0;
            if (s_tuser[0] == KIND_ENQ)
                status_next = full ? ST_FULL : ST_ENQUEUED;
            else if (empty)
                status_next = ST_EMPTY;
            else
            begin
                status_next    = ST_DEQUEUED;
                out_value_next = cells[0].value;
                out_prio_next  = cells[0].prio;
            end
        end
    end

    // Hold output valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Hold output payload
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        out_prio_reg  <= out_prio_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_prio_reg, out_value_reg};
    assign m_tuser  = status_reg;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import spq_pkg::*;

    logic  s_acc, s_enq, enq_status, no_data, m_stall;
    assign s_acc      = s_tvalid && s_tready;
    assign s_enq      = s_acc && (s_tuser[0] == KIND_ENQ);
    assign enq_status = (m_tuser == ST_ENQUEUED) || (m_tuser == ST_FULL);
    assign no_data    = m_tvalid && (m_tuser != ST_DEQUEUED);
    assign m_stall    = m_tvalid && !m_tready;

    // Only a successful dequeue carries data
    `SPQ_ASSERT_IMP(a_zero_data, clk, rst_n, no_data, m_tdata == '0)

    // An enqueue reports only an enqueue status
    `SPQ_ASSERT_NXT(a_enq_status, clk, rst_n, s_enq, m_tvalid && enq_status)

    // A held result blocks new input
    `SPQ_ASSERT_IMP(a_stall_blocks, clk, rst_n, m_stall, !s_tready)

    // A stalled result word holds
    `SPQ_ASSERT_NXT(a_stall_hold, clk, rst_n, m_stall, m_tvalid && $stable({m_tdata, m_tuser}))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
